FILE: sv/jsu_pkg.sv
// Shared types, codes and the UTF-8 encoder for the JSON string unescaper.
`default_nettype none

package jsu_pkg;

	typedef enum logic [1:0] {
		K_BYTE     = 2'd0,
		K_CLOSED   = 2'd1,
		K_ILLEGAL  = 2'd2,
		K_UNCLOSED = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} item_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_byte;
		logic       last;
	} result_t;

	// results caused by one input beat: up to four bytes, or one finishing code
	typedef struct packed {
		kind_t           kind;
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
	} grp_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [15:0] SURR_LO = 16'hD800;
	localparam logic [15:0] SURR_LOW_HALF = 16'hDC00;
	localparam logic [15:0] SURR_HI = 16'hDFFF;
	// 0x10000 >> 10, added to the high surrogate field
	localparam logic [10:0] PLANE1_HI = 11'd64;

	// bit 4 set marks a valid hex digit, bits 3:0 its value
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] r;
		r = '0;
		if (b inside {[8'h30:8'h39]})
			r = {1'b1, 4'(b - 8'h30)};
		else if (b inside {[8'h41:8'h46]})
			r = {1'b1, 4'(b - 8'h37)};
		else if (b inside {[8'h61:8'h66]})
			r = {1'b1, 4'(b - 8'h57)};
		return r;
	endfunction

	function automatic grp_t utf8_group(input logic [20:0] cp);
		grp_t g;
		g = '0;
		g.kind = K_BYTE;
		if (cp <= 21'h7F) begin
			g.bytes[0] = cp[7:0];
			g.last_idx = 2'd0;
		end else if (cp <= 21'h7FF) begin
			g.bytes[0] = {3'b110, cp[10:6]};
			g.bytes[1] = {2'b10, cp[5:0]};
			g.last_idx = 2'd1;
		end else if (cp <= 21'hFFFF) begin
			g.bytes[0] = {4'b1110, cp[15:12]};
			g.bytes[1] = {2'b10, cp[11:6]};
			g.bytes[2] = {2'b10, cp[5:0]};
			g.last_idx = 2'd2;
		end else begin
			g.bytes[0] = {5'b11110, cp[20:18]};
			g.bytes[1] = {2'b10, cp[17:12]};
			g.bytes[2] = {2'b10, cp[11:6]};
			g.bytes[3] = {2'b10, cp[5:0]};
			g.last_idx = 2'd3;
		end
		return g;
	endfunction

endpackage

`default_nettype wire

FILE: sv/jsu_decode.sv
// Escape decoder: parse state and the result group for each accepted beat.
`default_nettype none

module jsu_decode (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           take,
	input  wire jsu_pkg::item_t item,
	output jsu_pkg::grp_t       grp,
	output logic                push
);
	import jsu_pkg::*;

	typedef enum logic [6:0] {
		PH_OPEN       = 7'b0000001,
		PH_BODY       = 7'b0000010,
		PH_ESC        = 7'b0000100,
		PH_HEX_FIRST  = 7'b0001000,
		PH_PAIR_SLASH = 7'b0010000,
		PH_PAIR_U     = 7'b0100000,
		PH_HEX_SECOND = 7'b1000000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [1:0]  hcnt_q, hcnt_d;
	logic [15:0] acc_q, acc_d;
	logic [9:0]  hi_q, hi_d;

	logic [7:0]  b;
	logic        eot;
	logic [4:0]  hexv;
	logic [15:0] acc_nx;
	logic        fin, emit_cp, emit1;
	kind_t       fkind;
	logic [20:0] cp;
	logic [7:0]  lit;

	assign b = item.text_byte;
	assign eot = item.end_of_text;
	assign hexv = hex_value(b);
	assign acc_nx = {acc_q[11:0], hexv[3:0]};

	always_comb begin
		phase_d = phase_q;
		hcnt_d = hcnt_q;
		acc_d = acc_q;
		hi_d = hi_q;
		fin = 1'b0;
		fkind = K_ILLEGAL;
		emit_cp = 1'b0;
		emit1 = 1'b0;
		cp = '0;
		lit = b;
		case (phase_q)
			PH_BODY: begin
				if (eot) begin
					fin = 1'b1;
					fkind = K_UNCLOSED;
				end else if (b == CH_QUOTE) begin
					fin = 1'b1;
					fkind = K_CLOSED;
				end else if (b == CH_BSLASH) begin
					phase_d = PH_ESC;
				end else if (b inside {8'h08, 8'h09, 8'h0A, 8'h0C, 8'h0D}) begin
					fin = 1'b1;
				end else begin
					emit1 = 1'b1;
				end
			end
			PH_ESC: begin
				if (eot) begin
					fin = 1'b1;
					fkind = K_UNCLOSED;
				end else begin
					phase_d = PH_BODY;
					emit1 = 1'b1;
					case (b)
						8'h22: lit = 8'h22;
						8'h5C: lit = 8'h5C;
						8'h6E: lit = 8'h0A; // n
						8'h72: lit = 8'h0D; // r
						8'h74: lit = 8'h09; // t
						8'h66: lit = 8'h0C; // f
						8'h62: lit = 8'h08; // b
						8'h75, 8'h55: begin
							emit1 = 1'b0;
							phase_d = PH_HEX_FIRST;
							hcnt_d = '0;
							acc_d = '0;
						end
						default: begin
							emit1 = 1'b0;
							fin = 1'b1;
						end
					endcase
				end
			end
			PH_HEX_FIRST, PH_HEX_SECOND: begin
				if (eot || !hexv[4]) begin
					fin = 1'b1;
				end else if (hcnt_q != 2'd3) begin
					acc_d = acc_nx;
					hcnt_d = hcnt_q + 2'd1;
				end else begin
					hcnt_d = '0;
					acc_d = '0;
					if (phase_q == PH_HEX_FIRST) begin
						if (acc_nx inside {[SURR_LO:SURR_HI]}) begin
							if (acc_nx >= SURR_LOW_HALF) begin
								fin = 1'b1;
							end else begin
								hi_d = acc_nx[9:0];
								phase_d = PH_PAIR_SLASH;
							end
						end else begin
							cp = {5'd0, acc_nx};
							emit_cp = 1'b1;
							phase_d = PH_BODY;
						end
					end else begin
						if (acc_nx inside {[SURR_LOW_HALF:SURR_HI]}) begin
							cp = {11'(hi_q) + PLANE1_HI, acc_nx[9:0]};
							emit_cp = 1'b1;
							phase_d = PH_BODY;
						end else begin
							fin = 1'b1;
						end
					end
				end
			end
			PH_PAIR_SLASH: begin
				if (eot || b != CH_BSLASH)
					fin = 1'b1;
				else
					phase_d = PH_PAIR_U;
			end
			PH_PAIR_U: begin
				if (eot || b != 8'h75) begin
					fin = 1'b1;
				end else begin
					phase_d = PH_HEX_SECOND;
					hcnt_d = '0;
					acc_d = '0;
				end
			end
			default: begin
				// opening quote consumed unchecked
				if (eot) begin
					fin = 1'b1;
					fkind = K_UNCLOSED;
				end else begin
					phase_d = PH_BODY;
				end
			end
		endcase

		grp = '0;
		grp.kind = K_BYTE;
		push = 1'b0;
		if (fin) begin
			phase_d = PH_OPEN;
			hcnt_d = '0;
			acc_d = '0;
			hi_d = '0;
			grp.kind = fkind;
			push = 1'b1;
		end else if (emit_cp) begin
			grp = utf8_group(cp);
			push = 1'b1;
		end else if (emit1) begin
			grp.bytes[0] = lit;
			push = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OPEN;
			hcnt_q <= '0;
			acc_q <= '0;
			hi_q <= '0;
		end else if (take) begin
			phase_q <= phase_d;
			hcnt_q <= hcnt_d;
			acc_q <= acc_d;
			hi_q <= hi_d;
		end
	end

endmodule

`default_nettype wire

FILE: sv/json_string_unescaper.sv
// Top level of the JSON string unescaper: decoder, two-group result queue, byte serializer.
//
//   channel | dir | handshake                  | beat
//   item    | in  | item_valid / item_stall    | text_byte, end_of_text
//   result  | out | result_valid / result_stall| kind, out_byte, last
//
// One input beat is decoded per cycle while item_stall is low, into a group of 0 to 4 results,
// queued in a two-entry group queue; results leave one beat per cycle while result_stall is low.
// Output rate bounds throughput: each byte of an expanded item leaves as a beat of its own.
// A result appears at the earliest the cycle after its input beat is accepted.
// Reset returns to waiting for an opening quote with an empty queue.
// item_stall rises only when both queue entries hold groups.
`default_nettype none

module json_string_unescaper (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire jsu_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output jsu_pkg::result_t      result
);
	import jsu_pkg::*;

	grp_t       dec_grp;
	logic       dec_push;
	logic       take, push, pop_beat, pop_grp;
	grp_t       gq_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	grp_t       head;

	assign item_stall = (cnt_q == 2'd2);
	assign take = item_valid && !item_stall;
	assign push = take && dec_push;

	jsu_decode u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item),
		.grp    (dec_grp),
		.push   (dec_push)
	);

	assign head = gq_q[rd_ptr_q];
	assign result_valid = (cnt_q != 2'd0);
	assign result.kind = head.kind;
	assign result.out_byte = head.bytes[idx_q];
	assign result.last = (idx_q == head.last_idx);
	assign pop_beat = result_valid && !result_stall;
	assign pop_grp = pop_beat && result.last;

	always_ff @(posedge clk) begin
		if (push)
			gq_q[wr_ptr_q] <= dec_grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop_grp) begin
				rd_ptr_q <= !rd_ptr_q;
				idx_q <= '0;
			end else if (pop_beat) begin
				idx_q <= idx_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_grp};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("group queue count out of range");

	a_code_alone: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != K_BYTE |-> result.last && result.out_byte == 8'd0)
		else $error("finishing code not a lone zero-byte last beat");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		pop_beat && !result.last |=> idx_q == $past(idx_q) + 2'd1 && result_valid)
		else $error("byte index did not advance within a group");

	a_full_no_push: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 && !pop_grp |=> cnt_q == 2'd2)
		else $error("full queue changed without a group leaving");

endmodule

`default_nettype wire
